>>> rtl/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

    // table geometry
    localparam int TASK_SLOTS = 8;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int RESULT_CAP = 8;
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);

    // field widths
    localparam int TAG_W   = 16;
    localparam int CD_W    = 16;
    localparam int PEND_W  = 8;
    localparam int TICK_W  = 32;
    localparam int SFLD_W  = 3;

    // input operation codes
    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_DSTART = 2'd2,
        FUNC_DEND  = 2'd3
    } func_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_ADDED   = 3'd0,
        KIND_REJECT  = 3'd1,
        KIND_TICK    = 3'd2,
        KIND_DUE     = 3'd3,
        KIND_NONE    = 3'd4,
        KIND_DEND    = 3'd5
    } kind_t;

    // controller to slot cells, broadcast
    typedef struct packed {
        logic              load;      // put the scan token in cell 0
        logic              step;      // shift the token one cell up
        logic              clear;     // drop the token
        logic              tick;      // advance every used slot
        logic              take_add;  // token cell stores the new task
        logic              take_disp; // token cell consumes one pending run
        logic [TAG_W-1:0]  tag;
        logic [CD_W-1:0]   delay;
        logic [CD_W-1:0]   reload;
    } cell_cmd_t;

    // token cell status, zero from cells without the token
    typedef struct packed {
        logic              used;
        logic              pend_nz;
        logic [TAG_W-1:0]  tag;
    } cell_stat_t;

endpackage

>>> rtl/tick_task_scheduler_unit.sv
`timescale 1ns / 1ps
// Order: tick, dispatch end and a dispatch with nothing due pass from the state register
// to the output registers; an add and a dispatch walk the scan token up the slot cells,
// one cell per cycle while the result register is free to take a beat.
// Throughput: one input beat at a time; the next is taken the cycle after the last
// result beat is registered, so output stalls hold the input side too.
// Reset: synchronous, active low, clears the whole table, counters and flags at once.

module tick_task_scheduler_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // task_tag[15:0], start_delay[31:16], run_period[47:32]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // slot[2:0], due_tag[18:3], overrun[19],
                                   // cycle_count[51:20], zero[55:52]
    output logic [2:0]  m_tuser,   // kind[2:0]
    output logic        m_tlast
);
    import tts_pkg::*;

    cell_cmd_t             cmd;
    cell_stat_t            sel;
    cell_stat_t            stat [TASK_SLOTS];
    logic [TASK_SLOTS:0]   tok;
    logic [TASK_SLOTS-1:0] pend_vec;

    // cell 0 takes the token from the load input
    assign tok[0] = cmd.load;

    // row of slot cells
    for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
        tts_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .pend_nz (pend_vec[i]),
            .stat    (stat[i])
        );
    end

    // token cell status onto the shared bus
    always_comb begin
        sel = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            sel = sel | stat[i];
        end
    end

    tts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sel      (sel),
        .pend_vec (pend_vec)
    );

endmodule

>>> rtl/tts_cell.sv
`timescale 1ns / 1ps

module tts_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  tts_pkg::cell_cmd_t cmd,
    input  logic               tok_in,
    output logic               tok_out,
    output logic               pend_nz,
    output tts_pkg::cell_stat_t stat
);
    import tts_pkg::*;

    logic              tok_reg, tok_next;
    logic              used_reg, used_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [CD_W-1:0]   cd_reg, cd_next;
    logic [CD_W-1:0]   reload_reg, reload_next;
    logic [PEND_W-1:0] pend_reg, pend_next;

    // token shift along the row
    always_comb begin
        tok_next = tok_reg;
        if (cmd.clear) begin
            tok_next = 1'b0;
        end else if (cmd.load) begin
            tok_next = tok_in;
        end else if (cmd.step) begin
            tok_next = tok_in;
        end
    end

    // slot state update
    always_comb begin
        used_next   = used_reg;
        tag_next    = tag_reg;
        cd_next     = cd_reg;
        reload_next = reload_reg;
        pend_next   = pend_reg;
        if (cmd.tick && used_reg) begin
            if (cd_reg == '0) begin
                if (pend_reg != {PEND_W{1'b1}}) begin
                    pend_next = pend_reg + 1'b1;
                end
                cd_next = reload_reg;
            end else begin
                cd_next = cd_reg - 1'b1;
            end
        end
        if (cmd.take_add && tok_reg) begin
            used_next   = 1'b1;
            tag_next    = cmd.tag;
            cd_next     = cmd.delay;
            reload_next = cmd.reload;
            pend_next   = '0;
        end
        if (cmd.take_disp && tok_reg) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg    <= 1'b0;
            used_reg   <= 1'b0;
            tag_reg    <= '0;
            cd_reg     <= '0;
            reload_reg <= '0;
            pend_reg   <= '0;
        end else begin
            tok_reg    <= tok_next;
            used_reg   <= used_next;
            tag_reg    <= tag_next;
            cd_reg     <= cd_next;
            reload_reg <= reload_next;
            pend_reg   <= pend_next;
        end
    end

    assign tok_out = tok_reg;
    assign pend_nz = (pend_reg != '0);

    // status shows only from the token cell
    assign stat.used    = tok_reg & used_reg;
    assign stat.pend_nz = tok_reg & pend_nz;
    assign stat.tag     = tok_reg ? tag_reg : '0;

endmodule

>>> rtl/tts_ctrl.sv
`timescale 1ns / 1ps

module tts_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,   // task_tag, start_delay, run_period
    input  logic [1:0]                    s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [55:0]                   m_tdata,   // slot, due_tag, overrun, cycle_count
    output logic [2:0]                    m_tuser,   // kind
    output logic                          m_tlast,
    output tts_pkg::cell_cmd_t            cmd,
    input  tts_pkg::cell_stat_t           sel,
    input  logic [tts_pkg::TASK_SLOTS-1:0] pend_vec
);
    import tts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK,
        ST_DISP,
        ST_NONE,
        ST_DEND
    } state_t;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [TICK_W-1:0]  ticks_reg, ticks_next;
    logic               open_reg, open_next;
    logic               ovr_reg, ovr_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [CD_W-1:0]    delay_reg, delay_next;
    logic [CD_W-1:0]    period_reg, period_next;

    logic               mv_reg, mv_next;
    kind_t              mk_reg, mk_next;
    logic [SFLD_W-1:0]  ms_reg, ms_next;
    logic [TAG_W-1:0]   mt_reg, mt_next;
    logic               mo_reg, mo_next;
    logic [TICK_W-1:0]  mc_reg, mc_next;
    logic               ml_reg, ml_next;

    logic               accept;
    logic               out_free;
    logic               at_end;
    logic               any_above;
    logic               is_last;
    logic [TASK_SLOTS-1:0] above;

    assign accept   = s_tvalid && (state_reg == ST_IDLE);
    assign out_free = !mv_reg || m_tready;
    assign at_end   = (idx_reg == SLOT_W'(TASK_SLOTS - 1));

    // slots above the token position with runs waiting
    always_comb begin
        for (int j = 0; j < TASK_SLOTS; j++) begin
            above[j] = (j > int'(idx_reg));
        end
    end
    assign any_above = |(pend_vec & above);
    assign is_last   = (n_reg == CNT_W'(RESULT_CAP - 1)) || !any_above;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        ticks_next  = ticks_reg;
        open_next   = open_reg;
        ovr_next    = ovr_reg;
        tag_next    = tag_reg;
        delay_next  = delay_reg;
        period_next = period_reg;
        mv_next     = mv_reg && !m_tready;
        mk_next     = mk_reg;
        ms_next     = ms_reg;
        mt_next     = mt_reg;
        mo_next     = mo_reg;
        mc_next     = mc_reg;
        ml_next     = ml_reg;

        cmd           = '0;
        cmd.tag       = tag_reg;
        cmd.delay     = delay_reg;
        cmd.reload    = period_reg - 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    tag_next    = s_tdata[15:0];
                    delay_next  = s_tdata[31:16];
                    period_next = s_tdata[47:32];
                    idx_next    = '0;
                    n_next      = '0;
                    unique case (func_t'(s_tuser))
                        FUNC_ADD: begin
                            state_next = ST_ADD;
                            cmd.load   = 1'b1;
                        end
                        FUNC_TICK: begin
                            state_next = ST_TICK;
                        end
                        FUNC_DSTART: begin
                            open_next = 1'b1;
                            if (|pend_vec) begin
                                state_next = ST_DISP;
                                cmd.load   = 1'b1;
                            end else begin
                                state_next = ST_NONE;
                            end
                        end
                        FUNC_DEND: begin
                            state_next = ST_DEND;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    mo_next = ovr_reg;
                    mc_next = ticks_reg;
                    mt_next = '0;
                    ml_next = 1'b1;
                    if (period_reg == '0 || (sel.used && at_end)) begin
                        // zero period or table full
                        mv_next    = 1'b1;
                        mk_next    = KIND_REJECT;
                        ms_next    = '0;
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else if (!sel.used) begin
                        mv_next      = 1'b1;
                        mk_next      = KIND_ADDED;
                        ms_next      = SFLD_W'(idx_reg);
                        cmd.take_add = 1'b1;
                        cmd.clear    = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_TICK: begin
                if (out_free) begin
                    cmd.tick   = 1'b1;
                    ticks_next = ticks_reg + 1'b1;
                    ovr_next   = ovr_reg | open_reg;
                    mv_next    = 1'b1;
                    mk_next    = KIND_TICK;
                    ms_next    = '0;
                    mt_next    = '0;
                    mo_next    = ovr_reg | open_reg;
                    mc_next    = ticks_reg + 1'b1;
                    ml_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DISP: begin
                if (out_free) begin
                    if (sel.pend_nz) begin
                        mv_next       = 1'b1;
                        mk_next       = KIND_DUE;
                        ms_next       = SFLD_W'(idx_reg);
                        mt_next       = sel.tag;
                        mo_next       = ovr_reg;
                        mc_next       = ticks_reg;
                        ml_next       = is_last;
                        cmd.take_disp = 1'b1;
                        n_next        = n_reg + 1'b1;
                    end
                    if ((sel.pend_nz && is_last) || at_end) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mk_next    = KIND_NONE;
                    ms_next    = '0;
                    mt_next    = '0;
                    mo_next    = ovr_reg;
                    mc_next    = ticks_reg;
                    ml_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DEND: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mk_next    = KIND_DEND;
                    ms_next    = '0;
                    mt_next    = '0;
                    mo_next    = ovr_reg;
                    mc_next    = ticks_reg;
                    ml_next    = 1'b1;
                    ovr_next   = 1'b0;
                    open_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            n_reg     <= '0;
            ticks_reg <= '0;
            open_reg  <= 1'b0;
            ovr_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            ticks_reg <= ticks_next;
            open_reg  <= open_next;
            ovr_reg   <= ovr_next;
            mv_reg    <= mv_next;
        end
        tag_reg    <= tag_next;
        delay_reg  <= delay_next;
        period_reg <= period_next;
        mk_reg     <= mk_next;
        ms_reg     <= ms_next;
        mt_reg     <= mt_next;
        mo_reg     <= mo_next;
        mc_reg     <= mc_next;
        ml_reg     <= ml_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tuser  = mk_reg;
    assign m_tlast  = ml_reg;
    assign m_tdata  = {4'd0, mc_reg, mo_reg, mt_reg, ms_reg};

endmodule

>>> rtl/tts_checker.sv
`timescale 1ns / 1ps

module tts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import tts_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result beat changed");

    // one input in flight: input side closes after a beat
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // only defined kinds appear
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= KIND_DEND)
        else $error("undefined result kind");

    // every kind except task due is a single final beat
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_DUE) |-> m_tlast)
        else $error("single result beat without last");

    // dispatched slot beats carry no input-side acceptance
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open during dispatch");

endmodule

bind tick_task_scheduler_unit tts_checker u_tts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> bench/tick_task_scheduler_unit_test.sv
`timescale 1ns / 1ps

import tts_pkg::*;

// one expected result beat
typedef struct {
    kind_t              kind;
    logic [SFLD_W-1:0]  slot;
    logic [TAG_W-1:0]   due_tag;
    logic               overrun;
    logic [TICK_W-1:0]  ticks;
    logic               last;
} sched_beat_t;

// task table predictor plus the queue of beats still owed by the block
class task_table_model;
    bit                 used      [TASK_SLOTS];
    logic [TAG_W-1:0]   tag_of    [TASK_SLOTS];
    logic [CD_W-1:0]    countdown [TASK_SLOTS];
    logic [CD_W-1:0]    reload    [TASK_SLOTS];
    logic [PEND_W-1:0]  pending   [TASK_SLOTS];
    logic [TICK_W-1:0]  ticks;
    bit                 disp_open;
    bit                 overrun;
    sched_beat_t        awaited_beats[$];
    int                 errors;

    function new();
        for (int i = 0; i < TASK_SLOTS; i++) begin
            used[i]      = 1'b0;
            tag_of[i]    = '0;
            countdown[i] = '0;
            reload[i]    = '0;
            pending[i]   = '0;
        end
        ticks     = '0;
        disp_open = 1'b0;
        overrun   = 1'b0;
        errors    = 0;
    endfunction

    function void owe_beat(kind_t k, int s, logic [TAG_W-1:0] t, bit ovr, bit l);
        sched_beat_t b;
        b.kind    = k;
        b.slot    = SFLD_W'(s);
        b.due_tag = t;
        b.overrun = ovr;
        b.ticks   = ticks;
        b.last    = l;
        awaited_beats.push_back(b);
    endfunction

    // advance the table for one accepted command and queue its beats
    function void apply_command(func_t f, logic [TAG_W-1:0] tag,
                                logic [CD_W-1:0] delay, logic [CD_W-1:0] period);
        int free_idx;
        int n;
        bit was;
        case (f)
            FUNC_ADD: begin
                free_idx = TASK_SLOTS;
                if (period != 0) begin
                    for (int i = TASK_SLOTS - 1; i >= 0; i--)
                        if (!used[i]) free_idx = i;
                end
                if (free_idx >= TASK_SLOTS) begin
                    owe_beat(KIND_REJECT, 0, '0, overrun, 1'b1);
                end else begin
                    used[free_idx]      = 1'b1;
                    tag_of[free_idx]    = tag;
                    countdown[free_idx] = delay;
                    reload[free_idx]    = period - 1'b1;
                    pending[free_idx]   = '0;
                    owe_beat(KIND_ADDED, free_idx, '0, overrun, 1'b1);
                end
            end
            FUNC_TICK: begin
                if (disp_open) overrun = 1'b1;
                ticks = ticks + 1'b1;
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (used[i]) begin
                        if (countdown[i] == 0) begin
                            // pending runs saturate
                            if (pending[i] != '1) pending[i] = pending[i] + 1'b1;
                            countdown[i] = reload[i];
                        end else begin
                            countdown[i] = countdown[i] - 1'b1;
                        end
                    end
                end
                owe_beat(KIND_TICK, 0, '0, overrun, 1'b1);
            end
            FUNC_DSTART: begin
                n = 0;
                disp_open = 1'b1;
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (n < RESULT_CAP && pending[i] != 0) begin
                        owe_beat(KIND_DUE, i, tag_of[i], overrun, 1'b0);
                        pending[i] = pending[i] - 1'b1;
                        n++;
                    end
                end
                if (n == 0)
                    owe_beat(KIND_NONE, 0, '0, overrun, 1'b1);
                else
                    awaited_beats[awaited_beats.size() - 1].last = 1'b1;
            end
            default: begin
                // dispatch end reports the flag it clears
                was       = overrun;
                overrun   = 1'b0;
                disp_open = 1'b0;
                owe_beat(KIND_DEND, 0, '0, was, 1'b1);
            end
        endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // compare one accepted result beat against the oldest owed beat
    function void match_beat(kind_t k, logic [SFLD_W-1:0] s, logic [TAG_W-1:0] t,
                             logic ovr, logic [TICK_W-1:0] c, logic l);
        sched_beat_t exp_beat;
        if (awaited_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual kind %0d slot %0d",
                     $time, k, s);
            errors++;
            return;
        end
        exp_beat = awaited_beats.pop_front();
        compare_field("kind",        exp_beat.kind,    k);
        compare_field("slot",        exp_beat.slot,    s);
        compare_field("due_tag",     exp_beat.due_tag, t);
        compare_field("overrun",     exp_beat.overrun, ovr);
        compare_field("cycle_count", exp_beat.ticks,   c);
        compare_field("last",        exp_beat.last,    l);
    endfunction
endclass

module tick_task_scheduler_unit_test;

    localparam int RANDOM_ITEMS = 66;
    localparam int CALM_ITEMS   = 20;
    localparam int SAT_TICKS    = 260;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * TASK_SLOTS + 4;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // task_tag, start_delay, run_period
    logic [1:0]  s_tuser  = '0;   // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // slot, due_tag, overrun, cycle_count, zero pad
    logic [2:0]  m_tuser;         // kind
    logic        m_tlast;

    task_table_model sched_model;
    bit          calm_tail   = 1'b0;
    int          stall_left  = 0;
    int          quiet_cycles = 0;
    int          items_sent  = 0;

    tick_task_scheduler_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // result side backpressure in bursts
    always @(posedge aclk) begin
        if (!aresetn || calm_tail) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sched_model.match_beat(kind_t'(m_tuser), m_tdata[2:0], m_tdata[18:3],
                                   m_tdata[19], m_tdata[51:20], m_tlast);
    end

    // watchdog on cycles without any beat moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** tick_task_scheduler_unit: FAILED **");
            $finish;
        end
    end

    // one command beat, with an optional idle burst ahead of it
    task automatic send_item(input func_t f, input logic [15:0] tag,
                             input logic [15:0] delay, input logic [15:0] period);
        if (!calm_tail && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {period, delay, tag};
        s_tuser  <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sched_model.apply_command(f, tag, delay, period);
        items_sent++;
    endtask

    task automatic issue_random(input func_t f);
        logic [15:0] period;
        period = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
        send_item(f, 16'($urandom), 16'($urandom), period);
    endtask

    initial begin
        sched_model = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty dispatch, stray end, a reject, zero reload, overrun
        send_item(FUNC_DSTART, 16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_DEND,   16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_ADD,    16'h1111, 16'h0003, 16'h0000);
        send_item(FUNC_ADD,    16'hFFFF, 16'h0000, 16'h0001);
        send_item(FUNC_ADD,    16'h0000, 16'h0000, 16'h0002);
        send_item(FUNC_ADD,    16'hA5A5, 16'h0001, 16'h0003);
        send_item(FUNC_TICK,   16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_TICK,   16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(FUNC_DSTART, 16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_DSTART, 16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_TICK,   16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_DEND,   16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_DEND,   16'h0000, 16'h0000, 16'h0000);
        // fill the table, then one more add finds it full
        send_item(FUNC_ADD,    16'h5A5A, 16'hFFFF, 16'hFFFF);
        send_item(FUNC_ADD,    16'h1234, 16'h0002, 16'h0005);
        send_item(FUNC_ADD,    16'h8000, 16'h0003, 16'h0007);
        send_item(FUNC_ADD,    16'h0001, 16'h0000, 16'h0001);
        send_item(FUNC_ADD,    16'h7FFF, 16'h0004, 16'h0004);
        send_item(FUNC_ADD,    16'hC3C3, 16'h0000, 16'h0001);
        repeat (3) send_item(FUNC_TICK, 16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_DSTART, 16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_DEND,   16'h0000, 16'h0000, 16'h0000);

        // drive the every-tick slots into pending saturation
        repeat (SAT_TICKS) issue_random(FUNC_TICK);

        // random: mostly tick / dispatch rounds, some loose commands
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent > RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
            if ($urandom_range(9) < 7) begin
                repeat ($urandom_range(1, 4)) issue_random(FUNC_TICK);
                issue_random(FUNC_DSTART);
                if ($urandom_range(3) == 0) issue_random(FUNC_TICK);
                issue_random(FUNC_DEND);
            end else begin
                issue_random(func_t'($urandom_range(3)));
            end
        end
        s_tvalid <= 1'b0;

        // wait out owed beats, then give stray beats a chance to show
        while (sched_model.awaited_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sched_model.errors == 0 && sched_model.awaited_beats.size() == 0) begin
            $display("** tick_task_scheduler_unit: PASSED **");
        end else begin
            $display("** tick_task_scheduler_unit: FAILED **");
        end
        $finish;
    end

endmodule
